@@ rtl/core/crchd_pkg.sv @@
// ----------------------------------------------------------------------------
// crchd_pkg
// Shared types, constants and CRC16-CCITT helpers for the header deframer.
// ----------------------------------------------------------------------------
package crchd_pkg;

    // Header layout: two checksum bytes, then fourteen covered bytes
    localparam int HEADER_BYTES = 16;
    localparam int CRC_BYTES    = HEADER_BYTES - 2;

    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] CONT_LENGTH = 16'hffff;
    localparam logic [15:0] SKIP_MAX    = 16'hffff;
    localparam logic [15:0] CRC_RESET   = 16'hffff;

    typedef enum logic {
        KIND_HEADER  = 1'b0,
        KIND_PAYLOAD = 1'b1
    } t_kind;

    // One result beat
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic [31:0] evt_type;
        logic [31:0] src_id;
        logic [31:0] dest_id;
        logic [15:0] payload_length;
        logic        continued;
        logic [15:0] skipped;
        logic        last;
    } t_entry;

    // Front to queue write request
    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_push;

    // Queue fill status
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Advance the CRC register over one byte, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

    // CRC over the covered header bytes; element 0 is header byte 2.
    // Linear in its inputs, so this flattens to a fixed XOR tree.
    function automatic logic [15:0] crc16_window(
        input logic [15:0]                  init,
        input logic [CRC_BYTES-1:0][7:0]    data
    );
        logic [15:0] crc;
        crc = init;
        for (int k = 0; k < CRC_BYTES; k++) begin
            crc = crc16_byte(crc, data[k]);
        end
        return crc;
    endfunction

endpackage

@@ rtl/core/crchd_front.sv @@
// ----------------------------------------------------------------------------
// crchd_front
// Accepts raw bytes, holds the header window, checks the CRC and classifies
// each byte as window fill, skipped byte, header or payload beat.
// ----------------------------------------------------------------------------
module crchd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_in_byte,
    input  logic                 i_cfg_wr_en,
    input  logic [15:0]          i_cfg_wr_data,
    input  crchd_pkg::t_q_status i_q_status,
    output crchd_pkg::t_push     o_push
);

    localparam int WIN_DEPTH = crchd_pkg::HEADER_BYTES - 1;
    localparam logic [3:0] FILL_FULL = 4'(WIN_DEPTH);

    logic [7:0]  r_window [WIN_DEPTH];
    logic [7:0]  n_window [WIN_DEPTH];
    logic [3:0]  r_fill,       n_fill;
    logic        r_in_payload, n_in_payload;
    logic [15:0] r_bytes_left, n_bytes_left;
    logic [15:0] r_skip,       n_skip;
    logic [15:0] r_crc_init;

    logic [crchd_pkg::HEADER_BYTES-1:0][7:0] w_hdr;
    logic [crchd_pkg::CRC_BYTES-1:0][7:0]    w_cdata;
    logic [15:0] w_got;
    logic [15:0] w_want;
    logic [15:0] w_len;
    logic        w_match;
    logic        w_accept;
    logic        w_fin;

    // Candidate header: stored bytes plus the incoming one
    always_comb begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
            w_hdr[i] = r_window[i];
        end
        w_hdr[crchd_pkg::HEADER_BYTES-1] = i_in_byte;
        for (int k = 0; k < crchd_pkg::CRC_BYTES; k++) begin
            w_cdata[k] = w_hdr[k+2];
        end
    end

    assign w_got   = {w_hdr[0], w_hdr[1]};
    assign w_want  = crchd_pkg::crc16_window(r_crc_init, w_cdata);
    assign w_match = (w_got == w_want);
    assign w_len   = {w_hdr[2], w_hdr[3]};
    assign w_fin   = (r_bytes_left <= 16'd1);

    assign o_ready  = !i_q_status.full;
    assign w_accept = i_valid && o_ready;

    // Classify the beat and work out the next state
    always_comb begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
            n_window[i] = r_window[i];
        end
        n_fill       = r_fill;
        n_in_payload = r_in_payload;
        n_bytes_left = r_bytes_left;
        n_skip       = r_skip;
        o_push       = '0;

        if (w_accept) begin
            priority if (r_in_payload) begin
                // Pass the payload byte through
                o_push.valid          = 1'b1;
                o_push.entry.kind     = crchd_pkg::KIND_PAYLOAD;
                o_push.entry.data_byte = i_in_byte;
                o_push.entry.last     = w_fin;
                if (w_fin) begin
                    n_bytes_left = '0;
                    n_in_payload = 1'b0;
                end else begin
                    n_bytes_left = r_bytes_left - 16'd1;
                end
            end else if (r_fill != FILL_FULL) begin
                // Append to the window
                n_window[r_fill] = i_in_byte;
                n_fill           = r_fill + 4'd1;
            end else if (!w_match) begin
                // Drop the oldest byte and keep hunting
                for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                    n_window[i] = r_window[i+1];
                end
                n_window[WIN_DEPTH-1] = i_in_byte;
                if (r_skip != crchd_pkg::SKIP_MAX) begin
                    n_skip = r_skip + 16'd1;
                end
            end else begin
                // Header found: report it and empty the window
                o_push.valid                = 1'b1;
                o_push.entry.kind           = crchd_pkg::KIND_HEADER;
                o_push.entry.evt_type       = {w_hdr[4],  w_hdr[5],  w_hdr[6],  w_hdr[7]};
                o_push.entry.src_id         = {w_hdr[8],  w_hdr[9],  w_hdr[10], w_hdr[11]};
                o_push.entry.dest_id        = {w_hdr[12], w_hdr[13], w_hdr[14], w_hdr[15]};
                o_push.entry.payload_length = w_len;
                o_push.entry.continued      = (w_len == crchd_pkg::CONT_LENGTH);
                o_push.entry.skipped        = r_skip;
                o_push.entry.last           = (w_len == 16'd0);
                n_skip       = '0;
                n_fill       = '0;
                n_in_payload = (w_len != 16'd0);
                n_bytes_left = w_len;
            end
        end
    end

    // Window bytes are never read before they are written
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
            r_window[i] <= n_window[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_in_payload <= 1'b0;
            r_bytes_left <= '0;
            r_skip       <= '0;
        end else begin
            r_fill       <= n_fill;
            r_in_payload <= n_in_payload;
            r_bytes_left <= n_bytes_left;
            r_skip       <= n_skip;
        end
    end

    // CRC start value register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_init <= crchd_pkg::CRC_RESET;
        end else if (i_cfg_wr_en) begin
            r_crc_init <= i_cfg_wr_data;
        end
    end

endmodule

@@ rtl/core/crchd_queue.sv @@
// ----------------------------------------------------------------------------
// crchd_queue
// Short result queue between the classifying front and the output stage.
// ----------------------------------------------------------------------------
module crchd_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  crchd_pkg::t_push     i_push,
    input  logic                 i_pop,
    output crchd_pkg::t_entry    o_rd_data,
    output crchd_pkg::t_q_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    crchd_pkg::t_entry r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count,  n_count;
    logic              w_wr;
    logic              w_rd;

    assign o_status.full  = (r_count == CNT_FULL);
    assign o_status.empty = (r_count == '0);
    assign o_rd_data      = r_mem[r_rd_ptr];

    assign w_wr = i_push.valid && !o_status.full;
    assign w_rd = i_pop && !o_status.empty;

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({w_wr, w_rd})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

@@ rtl/core/crchd_back.sv @@
// ----------------------------------------------------------------------------
// crchd_back
// Output register stage: drains the queue and holds each result beat until
// the receiver takes it.
// ----------------------------------------------------------------------------
module crchd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  crchd_pkg::t_q_status i_q_status,
    input  crchd_pkg::t_entry    i_rd_data,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output crchd_pkg::t_entry    o_entry
);

    logic              r_valid, n_valid;
    crchd_pkg::t_entry r_entry;

    // Load a new beat when the register is empty or being taken
    assign o_pop   = !i_q_status.empty && (!r_valid || i_ready);
    assign n_valid = o_pop || (r_valid && !i_ready);

    assign o_valid = r_valid;
    assign o_entry = r_entry;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_entry <= i_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

@@ rtl/core/crc_header_packet_deframer_core.sv @@
// ----------------------------------------------------------------------------
// crc_header_packet_deframer_core
// Byte-stream deframer: hunts for a 16-byte header guarded by CRC16-CCITT,
// reports it, then forwards its payload bytes.
//
// Input channel: one raw link byte per beat on i_in_byte (i_in_valid /
// o_in_ready). Output channel: one result beat (o_out_valid / i_out_ready),
// either a header (o_kind = 0) or a payload byte (o_kind = 1), with o_last on
// the final beat of a packet. Bytes that fill the window or are skipped while
// hunting give no output beat.
// Throughput: one byte per cycle while the queue is not full; the CRC over
// the fourteen covered bytes is a combinational XOR tree in the front stage.
// Path: a result is written to the queue at the edge that accepts its byte
// and moves to the output register once that register is empty or taken.
// Stall: results collect in a QUEUE_DEPTH-entry queue; the input is held off
// only when that queue is full, so the front keeps taking bytes while a beat
// waits at the output.
// Reset: window empty, hunting, skip count zero, crc_init = 0xffff. No
// clearing pass; bytes are taken from the first cycle after reset. The user
// must write crc_init through i_cfg_wr_en/i_cfg_wr_data while idle; unchecked.
// ----------------------------------------------------------------------------
module crc_header_packet_deframer_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_kind,
    output logic [7:0]  o_data_byte,
    output logic [31:0] o_evt_type,
    output logic [31:0] o_src_id,
    output logic [31:0] o_dest_id,
    output logic [15:0] o_payload_length,
    output logic        o_continued,
    output logic [15:0] o_skipped,
    output logic        o_last
);

    crchd_pkg::t_push     w_push;
    crchd_pkg::t_q_status w_q_status;
    crchd_pkg::t_entry    w_rd_data;
    crchd_pkg::t_entry    w_out;
    logic                 w_pop;

    // Classify incoming bytes
    crchd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_in_byte     (i_in_byte),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_status    (w_q_status),
        .o_push        (w_push)
    );

    // Decouple front and output stage
    crchd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_pop     (w_pop),
        .o_rd_data (w_rd_data),
        .o_status  (w_q_status)
    );

    // Present results to the receiver
    crchd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (w_q_status),
        .i_rd_data  (w_rd_data),
        .o_pop      (w_pop),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_entry    (w_out)
    );

    assign o_kind           = w_out.kind;
    assign o_data_byte      = w_out.data_byte;
    assign o_evt_type       = w_out.evt_type;
    assign o_src_id         = w_out.src_id;
    assign o_dest_id        = w_out.dest_id;
    assign o_payload_length = w_out.payload_length;
    assign o_continued      = w_out.continued;
    assign o_skipped        = w_out.skipped;
    assign o_last           = w_out.last;

endmodule
